>>> sv/tld_pkg.sv
// shared types and constants of the terminal line discipline
// used by the front end, back end, top level and checker, no dependencies
`default_nettype none

package tld_pkg;

  localparam int LINE_MAX_DEF = 60;
  localparam int Q_DEPTH_DEF  = 4;
  localparam int LEN_W        = 6;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // mode_flags bit positions
  localparam int M_CRLF_IN = 0;
  localparam int M_CANON   = 1;
  localparam int M_ECHO    = 2;
  localparam int M_SIG     = 3;
  localparam int M_OPOST   = 4;

  localparam logic [4:0] MODE_MASK  = 5'h1F;
  localparam logic [4:0] MODE_RESET = 5'h1F;
  localparam logic [7:0] ERASE_RESET = 8'd8;
  localparam logic [7:0] EOL_RESET   = 8'd10;
  localparam logic [7:0] EOF_RESET   = 8'd4;
  localparam logic [7:0] INTR_RESET  = 8'd3;
  localparam logic [7:0] SUSP_RESET  = 8'd26;
  localparam logic [7:0] QUIT_RESET  = 8'd28;

  typedef enum logic [2:0] {
    CFG_MODE,
    CFG_ERASE,
    CFG_EOL,
    CFG_EOF,
    CFG_INTR,
    CFG_SUSP,
    CFG_QUIT
  } cfg_idx_t;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_SIG  = 2'd2;

  localparam logic [1:0] SIG_INTR = 2'd0;
  localparam logic [1:0] SIG_SUSP = 2'd1;
  localparam logic [1:0] SIG_QUIT = 2'd2;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_SIG,
    TAIL_RAW,
    TAIL_LINE
  } tail_t;

  typedef struct packed {
    logic [4:0] mode;
    logic [7:0] erase_ch;
    logic [7:0] eol_ch;
    logic [7:0] eof_ch;
    logic [7:0] intr_ch;
    logic [7:0] susp_ch;
    logic [7:0] quit_ch;
  } cfg_t;

  // one queued job for the back end
  typedef struct packed {
    logic             echo_en;
    logic             crlf;
    tail_t            tail;
    logic [7:0]       ch;
    logic [1:0]       sig;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/tld_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 61
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/tld_fifo.sv
// short register queue that carries jobs from front end to back end
// no dependencies
`default_nettype none

module tld_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

>>> sv/tld_front.sv
// front end: takes typed bytes, classifies them, keeps the line length,
// writes the line store and queues jobs; depends on tld_pkg
`default_nettype none

module tld_front #(
  parameter int LINE_MAX = tld_pkg::LINE_MAX_DEF,
  parameter int RAM_AW   = 6
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tld_pkg::cfg_t       cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  input  wire logic                q_full,
  output logic                     q_push,
  output tld_pkg::cmd_t            q_cmd,
  input  wire logic                line_done,
  output logic                     ram_we,
  output logic      [RAM_AW-1:0]   ram_waddr,
  output logic      [7:0]          ram_wdata
);

  logic [tld_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                      busy_r, busy_nxt;

  logic       acc;
  logic [7:0] ch;
  logic       canon, echo_on, is_erase, is_end, is_sig, has_room;
  logic [1:0] sig_code;

  assign in_ready  = !busy_r && !q_full;
  assign acc       = in_valid && in_ready;
  assign ram_waddr = len_r[RAM_AW-1:0];
  assign ram_wdata = ch;

  always_comb begin
    ch = in_byte;
    if (in_byte == tld_pkg::CH_CR && cfg.mode[tld_pkg::M_CRLF_IN]) begin
      ch = tld_pkg::CH_LF;
    end
    canon    = cfg.mode[tld_pkg::M_CANON];
    echo_on  = cfg.mode[tld_pkg::M_ECHO];
    has_room = len_r < tld_pkg::LEN_W'(LINE_MAX);
    // priority: erase, then end of line, then signal characters
    is_erase = canon && (ch == cfg.erase_ch);
    is_end   = canon && !is_erase && (ch == cfg.eol_ch || ch == cfg.eof_ch);
    is_sig   = !is_erase && !is_end && cfg.mode[tld_pkg::M_SIG] &&
               (ch == cfg.intr_ch || ch == cfg.susp_ch || ch == cfg.quit_ch);
    if (ch == cfg.intr_ch) begin
      sig_code = tld_pkg::SIG_INTR;
    end else if (ch == cfg.susp_ch) begin
      sig_code = tld_pkg::SIG_SUSP;
    end else begin
      sig_code = tld_pkg::SIG_QUIT;
    end
  end

  always_comb begin
    len_nxt       = len_r;
    busy_nxt      = busy_r;
    q_push        = 1'b0;
    ram_we        = 1'b0;
    q_cmd.echo_en = echo_on;
    q_cmd.tail    = tld_pkg::TAIL_NONE;
    q_cmd.ch      = ch;
    q_cmd.sig     = sig_code;
    q_cmd.len     = len_r + 1'b1;

    if (line_done) begin
      busy_nxt = 1'b0;
    end

    if (acc) begin
      if (is_erase) begin
        if (len_r != '0) begin
          len_nxt = len_r - 1'b1;
          q_push  = echo_on;
        end
      end else if (is_end) begin
        // eof is delivered but never echoed
        q_cmd.echo_en = echo_on && (ch == cfg.eol_ch);
        q_cmd.tail    = tld_pkg::TAIL_LINE;
        ram_we        = 1'b1;
        len_nxt       = '0;
        q_push        = 1'b1;
        busy_nxt      = 1'b1;
      end else if (is_sig) begin
        q_cmd.tail = tld_pkg::TAIL_SIG;
        len_nxt    = '0;
        q_push     = 1'b1;
      end else if (!canon) begin
        q_cmd.tail = tld_pkg::TAIL_RAW;
        q_push     = 1'b1;
      end else begin
        // line full: still echoed, not stored
        if (has_room) begin
          ram_we  = 1'b1;
          len_nxt = len_r + 1'b1;
        end
        q_push = echo_on;
      end
    end

    q_cmd.crlf = q_cmd.echo_en && cfg.mode[tld_pkg::M_OPOST] && (ch == tld_pkg::CH_LF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/tld_back.sv
// back end: pops jobs and streams echo, signal and reader results through
// the output register, reading committed lines from the store; uses tld_pkg
`default_nettype none

module tld_back #(
  parameter int RAM_AW = 6
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  output logic                     q_pop,
  input  wire tld_pkg::cmd_t       q_cmd,
  output logic                     ram_re,
  output logic      [RAM_AW-1:0]   ram_raddr,
  input  wire logic [7:0]          ram_rdata,
  output logic                     line_done,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [1:0]          out_kind,
  output logic      [7:0]          out_value,
  output logic                     out_last_of_run
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CR,
    S_ECHO,
    S_TAIL,
    S_LRD,
    S_LOUT
  } state_t;

  state_t                    state_r, state_nxt;
  tld_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [tld_pkg::LEN_W-1:0] idx_r, idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_kind_r, out_kind_nxt;
  logic [7:0]                out_value_r, out_value_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      slot_free, idx_last;

  function automatic state_t after_echo(tld_pkg::tail_t t);
    state_t s;
    case (t)
      tld_pkg::TAIL_SIG,
      tld_pkg::TAIL_RAW:  s = S_TAIL;
      tld_pkg::TAIL_LINE: s = S_LRD;
      default:            s = S_IDLE;
    endcase
    return s;
  endfunction

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_value       = out_value_r;
  assign out_last_of_run = out_last_r;
  assign ram_raddr       = idx_r[RAM_AW-1:0];
  assign slot_free       = !out_valid_r || out_ready;
  assign idx_last        = (idx_r + 1'b1) == cmd_r.len;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    ram_re        = 1'b0;
    line_done     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          idx_nxt = '0;
          if (q_cmd.crlf) begin
            state_nxt = S_CR;
          end else if (q_cmd.echo_en) begin
            state_nxt = S_ECHO;
          end else begin
            state_nxt = after_echo(q_cmd.tail);
          end
        end
      end
      S_CR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tld_pkg::KIND_ECHO;
          out_value_nxt = tld_pkg::CH_CR;
          out_last_nxt  = 1'b0;
          state_nxt     = S_ECHO;
        end
      end
      S_ECHO: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tld_pkg::KIND_ECHO;
          out_value_nxt = cmd_r.ch;
          out_last_nxt  = (cmd_r.tail == tld_pkg::TAIL_NONE);
          state_nxt     = after_echo(cmd_r.tail);
        end
      end
      S_TAIL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (cmd_r.tail == tld_pkg::TAIL_SIG) begin
            out_kind_nxt  = tld_pkg::KIND_SIG;
            out_value_nxt = 8'(cmd_r.sig);
          end else begin
            out_kind_nxt  = tld_pkg::KIND_READ;
            out_value_nxt = cmd_r.ch;
          end
          state_nxt = S_IDLE;
        end
      end
      S_LRD: begin
        ram_re    = 1'b1;
        state_nxt = S_LOUT;
      end
      S_LOUT: begin
        // read data holds until the next read, so waiting on the slot is safe
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tld_pkg::KIND_READ;
          out_value_nxt = ram_rdata;
          out_last_nxt  = idx_last;
          if (idx_last) begin
            line_done = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_LRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

>>> sv/tty_line_discipline.sv
// a byte's result passes the job queue, the back end state register and the
// output register (a line commit without echo starts with a line store read);
// the back end takes one job at a time from the queue, then sends each echo or
// signal result, and per delivered line byte a store read, then the output
// register load; a line commit holds off input until its last byte is loaded, the queue of
// Q_DEPTH jobs absorbs other bytes; reset: synchronous, active low, restores
// register defaults, empties line, queue and output register, not the line store
`default_nettype none

module tty_line_discipline #(
  parameter int LINE_MAX = tld_pkg::LINE_MAX_DEF,
  parameter int Q_DEPTH  = tld_pkg::Q_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [1:0] out_kind,
  output logic      [7:0] out_value,
  output logic            out_last_of_run
);

  localparam int RAM_DEPTH = LINE_MAX + 1;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int CMD_W     = $bits(tld_pkg::cmd_t);

  tld_pkg::cfg_t cfg_r, cfg_nxt;

  tld_pkg::cmd_t     push_cmd, pop_cmd;
  logic              q_push, q_pop, q_full, q_empty, line_done;
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        tld_pkg::CFG_MODE:  cfg_nxt.mode     = cfg_data[4:0] & tld_pkg::MODE_MASK;
        tld_pkg::CFG_ERASE: cfg_nxt.erase_ch = cfg_data;
        tld_pkg::CFG_EOL:   cfg_nxt.eol_ch   = cfg_data;
        tld_pkg::CFG_EOF:   cfg_nxt.eof_ch   = cfg_data;
        tld_pkg::CFG_INTR:  cfg_nxt.intr_ch  = cfg_data;
        tld_pkg::CFG_SUSP:  cfg_nxt.susp_ch  = cfg_data;
        tld_pkg::CFG_QUIT:  cfg_nxt.quit_ch  = cfg_data;
        default:            cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= tld_pkg::MODE_RESET;
      cfg_r.erase_ch <= tld_pkg::ERASE_RESET;
      cfg_r.eol_ch   <= tld_pkg::EOL_RESET;
      cfg_r.eof_ch   <= tld_pkg::EOF_RESET;
      cfg_r.intr_ch  <= tld_pkg::INTR_RESET;
      cfg_r.susp_ch  <= tld_pkg::SUSP_RESET;
      cfg_r.quit_ch  <= tld_pkg::QUIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tld_front #(
    .LINE_MAX (LINE_MAX),
    .RAM_AW   (RAM_AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .line_done (line_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  tld_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (pop_cmd),
    .empty (q_empty)
  );

  tld_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tld_back #(
    .RAM_AW (RAM_AW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_cmd           (pop_cmd),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .line_done       (line_done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

>>> sv/tld_checker.sv
// port level checks of the line discipline, bound to the top level
// depends on tld_pkg and tty_line_discipline
`default_nettype none

module tld_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_value,
  input wire logic       out_last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_value) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind != 2'd3)
    else $error("undefined result kind");

  // a signal always closes the run of its byte
  a_sig_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tld_pkg::KIND_SIG |-> out_last_of_run)
    else $error("signal result not last of run");

  a_sig_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tld_pkg::KIND_SIG |->
    out_value == 8'(tld_pkg::SIG_INTR) || out_value == 8'(tld_pkg::SIG_SUSP) ||
    out_value == 8'(tld_pkg::SIG_QUIT))
    else $error("bad signal code");

  // no result is offered right after reset
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind tty_line_discipline tld_checker u_chk (.*);

`default_nettype wire
